// ----- rtl/sfdl_pkg.sv -----
`timescale 1ns / 1ps
package sfdl_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = SAMPLE_W - 1;
   localparam int TANH_FRAC_W = FRAC_W - 3;
   localparam int TANH_SHIFT  = 12;
   localparam int TANH_IDX_W  = 5;

   localparam int DELAY_DEPTH_DEF = 131072;

   localparam int DELAY_REG_W = 17;
   localparam int FB_W        = 15;
   localparam int COEFF_W     = 15;
   localparam int GAIN_W      = 16;

   localparam int MUL_W  = 24;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SAT_W  = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY_LEFT    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DELAY_RIGHT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FEEDBACK_GAIN = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOWPASS_COEFF = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DRY_GAIN      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_WET_GAIN      = 3'd5;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] ST_MOD_MUL   = 4'd1;
   localparam logic [STEP_W-1:0] ST_MOD_SCALE = 4'd2;
   localparam logic [STEP_W-1:0] ST_MOD_FIX   = 4'd3;
   localparam logic [STEP_W-1:0] ST_READ      = 4'd4;
   localparam logic [STEP_W-1:0] ST_LP_MUL    = 4'd5;
   localparam logic [STEP_W-1:0] ST_LP_ADD    = 4'd6;
   localparam logic [STEP_W-1:0] ST_FB_MUL    = 4'd7;
   localparam logic [STEP_W-1:0] ST_CLIP_IN   = 4'd8;
   localparam logic [STEP_W-1:0] ST_CLIP_MUL  = 4'd9;
   localparam logic [STEP_W-1:0] ST_WRITE     = 4'd10;
   localparam logic [STEP_W-1:0] ST_DONE      = 4'd11;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [DELAY_REG_W-1:0] delay_left;
      logic [DELAY_REG_W-1:0] delay_right;
      logic [FB_W-1:0]        feedback_gain;
      logic [COEFF_W-1:0]     lowpass_coeff;
      logic [GAIN_W-1:0]      dry_gain;
      logic [GAIN_W-1:0]      wet_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      delay_left:    17'd9084,
      delay_right:   17'd9901,
      feedback_gain: 15'd4424,
      lowpass_coeff: 15'd22282,
      dry_gain:      16'd27034,
      wet_gain:      16'd11469
   };

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              ch;
      logic              start;
      logic              finish;
   } seq_ctrl_type;

   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(2 ** FRAC_W - 1);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(2 ** FRAC_W));

   function automatic sample_type sat_sample(input logic signed [SAT_W-1:0] v);
      sample_type r;
      if (v > SAT_HI) begin
         r = SAMPLE_W'(SAT_HI);
      end else if (v < SAT_LO) begin
         r = SAMPLE_W'(SAT_LO);
      end else begin
         r = SAMPLE_W'(v);
      end
      return r;
   endfunction

   // tanh over [0,2] in steps of 1/8, Q1.15; beyond the last point hold tanh(2)
   function automatic logic [15:0] tanh_lut(input logic [TANH_IDX_W-1:0] idx);
      logic [15:0] t;
      unique case (idx)
         5'd0:    t = 16'd0;
         5'd1:    t = 16'd4075;
         5'd2:    t = 16'd8026;
         5'd3:    t = 16'd11743;
         5'd4:    t = 16'd15143;
         5'd5:    t = 16'd18173;
         5'd6:    t = 16'd20813;
         5'd7:    t = 16'd23066;
         5'd8:    t = 16'd24956;
         5'd9:    t = 16'd26519;
         5'd10:   t = 16'd27797;
         5'd11:   t = 16'd28830;
         5'd12:   t = 16'd29660;
         5'd13:   t = 16'd30322;
         5'd14:   t = 16'd30847;
         5'd15:   t = 16'd31262;
         default: t = 16'd31589;
      endcase
      return t;
   endfunction

endpackage

// ----- rtl/sfdl_req_if.sv -----
`timescale 1ns / 1ps
interface sfdl_req_if;
   import sfdl_pkg::*;

   logic       valid;
   logic       ready;
   sample_type left_in;
   sample_type right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ----- rtl/sfdl_rsp_if.sv -----
`timescale 1ns / 1ps
interface sfdl_rsp_if;
   import sfdl_pkg::*;

   logic       valid;
   logic       ready;
   sample_type left_out;
   sample_type right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/sfdl_mul.sv -----
`timescale 1ns / 1ps
module sfdl_mul (
   input  logic                                clock,
   input  logic signed [sfdl_pkg::MUL_W-1:0]   a,
   input  logic signed [sfdl_pkg::MUL_W-1:0]   b,
   output logic signed [sfdl_pkg::PROD_W-1:0]  prod
);
   import sfdl_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/sfdl_seq.sv -----
`timescale 1ns / 1ps
module sfdl_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   output sfdl_pkg::seq_ctrl_type ctrl
);
   import sfdl_pkg::*;

   logic [STEP_W-1:0] state_ff, state_in;
   logic              ch_ff, ch_in;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ch_in = 1'b0;
            if (req_valid) begin
               state_in = ST_MOD_MUL;
            end
         end
         ST_MOD_MUL:   state_in = ST_MOD_SCALE;
         ST_MOD_SCALE: state_in = ST_MOD_FIX;
         ST_MOD_FIX:   state_in = ST_READ;
         ST_READ:      state_in = ST_LP_MUL;
         ST_LP_MUL:    state_in = ST_LP_ADD;
         ST_LP_ADD:    state_in = ST_FB_MUL;
         ST_FB_MUL:    state_in = ST_CLIP_IN;
         ST_CLIP_IN:   state_in = ST_CLIP_MUL;
         ST_CLIP_MUL:  state_in = ST_WRITE;
         ST_WRITE: begin
            // left done: run the same steps again for the right channel
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = ST_MOD_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               ch_in    = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ch_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   assign ctrl.step   = state_ff;
   assign ctrl.ch     = ch_ff;
   assign ctrl.start  = (state_ff == ST_IDLE) && req_valid;
   assign ctrl.finish = (state_ff == ST_DONE) && out_free;

endmodule

// ----- rtl/sfdl_datapath.sv -----
`timescale 1ns / 1ps
module sfdl_datapath #(
   parameter int DELAY_DEPTH = sfdl_pkg::DELAY_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sfdl_pkg::seq_ctrl_type ctrl,
   input  sfdl_pkg::cfg_type      cfg,
   input  sfdl_pkg::sample_type   in_left,
   input  sfdl_pkg::sample_type   in_right,
   output sfdl_pkg::sample_type   out_left,
   output sfdl_pkg::sample_type   out_right
);
   import sfdl_pkg::*;

   localparam int ADDR_W = $clog2(DELAY_DEPTH);
   localparam int CMP_W  = (ADDR_W + 1 > DELAY_REG_W) ? ADDR_W + 1 : DELAY_REG_W;
   // floor(2^17 / depth): quotient estimate is exact or one low
   localparam int RECIP  = (2 ** DELAY_REG_W) / DELAY_DEPTH;
   localparam logic [ADDR_W:0]  DEPTH_A = (ADDR_W + 1)'(DELAY_DEPTH);
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DELAY_DEPTH);
   localparam int X_W   = SAMPLE_W + 2;
   localparam int A_W   = SAMPLE_W + 1;
   localparam int ACC_W = 2 * SAMPLE_W + 2;
   localparam int TB_W  = 16 + TANH_FRAC_W;

   sample_type mem_l [DELAY_DEPTH];
   sample_type mem_r [DELAY_DEPTH];

   sample_type               in_l_ff, in_r_ff;
   logic [ADDR_W-1:0]        wr_ff;
   logic                     full_ff;
   logic [ADDR_W-1:0]        dmod_ff;
   logic                     hit_ff;
   sample_type               rdl_ff, rdr_ff;
   sample_type               del_ff;
   sample_type               lp_l_ff, lp_r_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [A_W-1:0]           a_ff;
   logic                     neg_ff;
   logic [TB_W-1:0]          tb_ff;
   sample_type               out_l_ff, out_r_ff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_rnd15;

   sample_type               in_sel, lp_sel, rdata_sel, del_cur, lp_new, out_val, wval;
   logic [DELAY_REG_W-1:0]   delay_sel;
   logic [DELAY_REG_W-1:0]   rem;
   logic [CMP_W-1:0]         rem_c;
   logic [ADDR_W-1:0]        dmod_in;
   logic [ADDR_W:0]          rd_diff;
   logic                     borrow;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     rd_hit;
   logic signed [SAMPLE_W:0] lp_diff;
   logic signed [X_W:0]      lp_sum;
   logic signed [X_W-1:0]    x_sum;
   logic [TANH_IDX_W-1:0]    idx_c;
   logic [TANH_FRAC_W-1:0]   frac_c;
   logic [15:0]              t0, t1;
   logic signed [16:0]       diff_t;
   logic signed [PROD_W-1:0] t_sum, t_rnd, t_signed;

   sfdl_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign in_sel    = ctrl.ch ? in_r_ff : in_l_ff;
   assign lp_sel    = ctrl.ch ? lp_r_ff : lp_l_ff;
   assign rdata_sel = ctrl.ch ? rdr_ff : rdl_ff;
   assign delay_sel = ctrl.ch ? cfg.delay_right : cfg.delay_left;

   assign prod_rnd15 = (prod + 48'sd16384) >>> 15;

   // delay modulo depth: prod holds quotient estimate times depth
   assign rem     = delay_sel - prod[DELAY_REG_W-1:0];
   assign rem_c   = CMP_W'(rem);
   assign dmod_in = (rem_c >= DEPTH_C) ? ADDR_W'(rem_c - DEPTH_C) : ADDR_W'(rem_c);

   assign rd_diff = {1'b0, wr_ff} - {1'b0, dmod_ff};
   assign borrow  = rd_diff[ADDR_W];
   assign rd_addr = borrow ? ADDR_W'(rd_diff + DEPTH_A) : rd_diff[ADDR_W-1:0];
   // entries behind the write pointer hold data; the rest read as zero until first wrap
   assign rd_hit  = full_ff || (!borrow && (dmod_ff != '0));

   assign del_cur = hit_ff ? rdata_sel : '0;
   assign lp_diff = (SAMPLE_W + 1)'(del_cur) - (SAMPLE_W + 1)'(lp_sel);
   assign lp_sum  = (X_W + 1)'(lp_sel) + (X_W + 1)'(prod_rnd15);
   assign lp_new  = sat_sample(SAT_W'(lp_sum));

   assign x_sum   = X_W'(in_sel) + X_W'(prod_rnd15);
   assign out_val = sat_sample(SAT_W'((acc_ff + 34'sd16384) >>> 15));

   assign idx_c  = a_ff[A_W-1] ? TANH_IDX_W'(16) : a_ff[A_W-1 -: TANH_IDX_W];
   assign frac_c = a_ff[A_W-1] ? '0 : a_ff[TANH_FRAC_W-1:0];
   assign t0     = tanh_lut(idx_c);
   assign t1     = tanh_lut(idx_c + TANH_IDX_W'(1));
   assign diff_t = $signed({1'b0, t1}) - $signed({1'b0, t0});

   assign t_sum    = PROD_W'($signed({1'b0, tb_ff})) + prod;
   assign t_rnd    = (t_sum + 48'sd2048) >>> TANH_SHIFT;
   assign t_signed = neg_ff ? -t_rnd : t_rnd;
   assign wval     = sat_sample(SAT_W'(t_signed));

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.step)
         ST_MOD_MUL: begin
            mul_a = MUL_W'($signed({1'b0, delay_sel}));
            mul_b = MUL_W'(RECIP);
         end
         ST_MOD_SCALE: begin
            mul_a = MUL_W'($signed({1'b0, prod[2*DELAY_REG_W-1:DELAY_REG_W]}));
            mul_b = MUL_W'(DELAY_DEPTH);
         end
         ST_MOD_FIX: begin
            mul_a = MUL_W'(in_sel);
            mul_b = MUL_W'($signed({1'b0, cfg.dry_gain}));
         end
         ST_LP_MUL: begin
            mul_a = MUL_W'(lp_diff);
            mul_b = MUL_W'($signed({1'b0, cfg.lowpass_coeff}));
         end
         ST_LP_ADD: begin
            mul_a = MUL_W'(del_ff);
            mul_b = MUL_W'($signed({1'b0, cfg.wet_gain}));
         end
         ST_FB_MUL: begin
            mul_a = MUL_W'(lp_sel);
            mul_b = MUL_W'($signed({1'b0, cfg.feedback_gain}));
         end
         ST_CLIP_MUL: begin
            mul_a = MUL_W'(diff_t);
            mul_b = MUL_W'($signed({1'b0, frac_c}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         in_l_ff <= in_left;
         in_r_ff <= in_right;
      end
      if (ctrl.step == ST_MOD_FIX) begin
         dmod_ff <= dmod_in;
      end
      if (ctrl.step == ST_READ) begin
         hit_ff <= rd_hit;
         acc_ff <= ACC_W'(prod);
      end
      if (ctrl.step == ST_LP_MUL) begin
         del_ff <= del_cur;
      end
      if (ctrl.step == ST_FB_MUL) begin
         acc_ff <= acc_ff + ACC_W'(prod);
      end
      if (ctrl.step == ST_CLIP_IN) begin
         neg_ff <= x_sum[X_W-1];
         a_ff   <= x_sum[X_W-1] ? A_W'(-x_sum) : A_W'(x_sum);
         if (ctrl.ch) begin
            out_r_ff <= out_val;
         end else begin
            out_l_ff <= out_val;
         end
      end
      if (ctrl.step == ST_CLIP_MUL) begin
         tb_ff <= {t0, {TANH_FRAC_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         full_ff <= 1'b0;
         lp_l_ff <= '0;
         lp_r_ff <= '0;
      end else begin
         if (ctrl.step == ST_LP_ADD) begin
            if (ctrl.ch) begin
               lp_r_ff <= lp_new;
            end else begin
               lp_l_ff <= lp_new;
            end
         end
         if (ctrl.finish) begin
            if (wr_ff == ADDR_W'(DELAY_DEPTH - 1)) begin
               wr_ff   <= '0;
               full_ff <= 1'b1;
            end else begin
               wr_ff <= wr_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step == ST_READ) begin
         rdl_ff <= mem_l[rd_addr];
      end
      if ((ctrl.step == ST_WRITE) && !ctrl.ch) begin
         mem_l[wr_ff] <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step == ST_READ) begin
         rdr_ff <= mem_r[rd_addr];
      end
      if ((ctrl.step == ST_WRITE) && ctrl.ch) begin
         mem_r[wr_ff] <= wval;
      end
   end

   assign out_left  = out_l_ff;
   assign out_right = out_r_ff;

endmodule

// ----- rtl/stereo_feedback_delay_lowpass.sv -----
// An accepted pair runs ten steps per channel, left then right, sharing one
// multiplier, then waits in ST_DONE until the previous result beat is taken;
// the finish loads the result registers. The block takes no beat until idle.
// Reset (synchronous, active high) clears control, filter states, write pointer
// and fill flag; unwritten delay entries read as zero until the pointer first
// wraps, so there is no clearing pass. Configuration registers return to their defaults.
`timescale 1ns / 1ps
module stereo_feedback_delay_lowpass #(
   parameter int DELAY_DEPTH = sfdl_pkg::DELAY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   sfdl_req_if.sink                            req_bus,
   sfdl_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [sfdl_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sfdl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sfdl_pkg::*;

   cfg_type      cfg_ff;
   seq_ctrl_type ctrl;
   logic         rsp_valid_ff;
   sample_type   rsp_l_ff, rsp_r_ff;
   sample_type   res_l, res_r;
   logic         out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DELAY_LEFT:    cfg_ff.delay_left    <= csr_wdata[DELAY_REG_W-1:0];
            CSR_DELAY_RIGHT:   cfg_ff.delay_right   <= csr_wdata[DELAY_REG_W-1:0];
            CSR_FEEDBACK_GAIN: cfg_ff.feedback_gain <= csr_wdata[FB_W-1:0];
            CSR_LOWPASS_COEFF: cfg_ff.lowpass_coeff <= csr_wdata[COEFF_W-1:0];
            CSR_DRY_GAIN:      cfg_ff.dry_gain      <= csr_wdata[GAIN_W-1:0];
            CSR_WET_GAIN:      cfg_ff.wet_gain      <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // hold the finished pair until the result beat is taken
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   sfdl_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   sfdl_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cfg       (cfg_ff),
      .in_left   (req_bus.left_in),
      .in_right  (req_bus.right_in),
      .out_left  (res_l),
      .out_right (res_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_l_ff <= res_l;
         rsp_r_ff <= res_r;
      end
   end

   assign req_bus.ready     = (ctrl.step == ST_IDLE);
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = rsp_l_ff;
   assign rsp_bus.right_out = rsp_r_ff;

   a_accept_starts_left: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (ctrl.step == ST_MOD_MUL) && !ctrl.ch)
      else $error("accepted beat did not start the left channel");

   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result loaded over an untaken beat");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_bus.valid && (ctrl.step == ST_IDLE))
      else $error("finished pair not presented");

endmodule
